// ===== design/quantized_dot_product_requant_defines.svh =====
// Assertion macros shared by the RTL that checks itself.
`ifndef QUANTIZED_DOT_PRODUCT_REQUANT_DEFINES_SVH
`define QUANTIZED_DOT_PRODUCT_REQUANT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define QDP_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qdp same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define QDP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qdp next-cycle check failed");

`endif

// ===== design/qdp_pkg.sv =====
package qdp_pkg;

  // Default accumulator width in int16 mode
  localparam int ACC_WIDTH_DEF = 64;

  // Accumulator width in int8 mode
  localparam int NARROW_ACC_W = 32;

  // Left-shift path: clamp magnitude to 2^20, shift by up to 32
  localparam int LSH_LIMIT = 1 << 20;
  localparam int LSH_W     = 55;

  // Output ranges
  localparam int WIDE_MAX   = 32767;
  localparam int WIDE_MIN   = -32768;
  localparam int NARROW_MAX = 127;
  localparam int NARROW_MIN = -128;

  // Configuration register indexes
  localparam logic [1:0] REG_SHIFT = 2'd0;
  localparam logic [1:0] REG_RELU  = 2'd1;
  localparam logic [1:0] REG_WIDE  = 2'd2;

  localparam int CFG_DATA_W = 6;

  typedef struct packed {
    logic signed [5:0] shift_amount;
    logic              relu_enable;
    logic              wide_mode;
  } qdp_cfg_t;

endpackage

// ===== design/qdp_mac.sv =====
module qdp_mac #(
  parameter int ACC_WIDTH = qdp_pkg::ACC_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wide_mode,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [15:0]   a_value,
  input  logic signed [15:0]   b_value,
  input  logic                 last_term,
  output logic                 sum_valid,
  input  logic                 sum_ready,
  output logic [ACC_WIDTH-1:0] sum_value
);

  localparam logic [ACC_WIDTH-1:0] LOW_MASK =
    {ACC_WIDTH{1'b1}} >> (ACC_WIDTH - qdp_pkg::NARROW_ACC_W);

  // operand stage
  logic               v1;
  logic signed [15:0] a1;
  logic signed [15:0] b1;
  logic               last1;
  // product stage
  logic               v2;
  logic signed [31:0] prod2;
  logic               last2;
  // accumulator and sum stage
  logic [ACC_WIDTH-1:0] acc;
  logic [ACC_WIDTH-1:0] acc_sum;
  logic                 v3;
  logic [ACC_WIDTH-1:0] sum3;

  logic signed [15:0] a_op;
  logic signed [15:0] b_op;
  logic ready1, ready2, ready3, move2;

  // stage flow: non-last items retire into the accumulator
  assign ready3   = !v3 || sum_ready;
  assign move2    = v2 && (!last2 || ready3);
  assign ready2   = !v2 || move2;
  assign ready1   = !v1 || ready2;
  assign in_ready = ready1;

  // int8 mode uses the sign-extended low byte
  assign a_op = wide_mode ? a_value : {{8{a_value[7]}}, a_value[7:0]};
  assign b_op = wide_mode ? b_value : {{8{b_value[7]}}, b_value[7:0]};

  // wrapping add at the mode's width
  always_comb begin
    acc_sum = acc + (ACC_WIDTH)'(prod2);
    if (!wide_mode) begin
      acc_sum = acc_sum & LOW_MASK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      acc <= '0;
    end else begin
      if (ready1) begin
        v1 <= in_valid;
      end
      if (ready2) begin
        v2 <= v1;
      end
      if (ready3) begin
        v3 <= move2 && last2;
      end
      if (move2) begin
        acc <= last2 ? '0 : acc_sum;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ready1) begin
      a1    <= a_op;
      b1    <= b_op;
      last1 <= last_term;
    end
    if (ready2) begin
      prod2 <= a1 * b1;
      last2 <= last1;
    end
    if (ready3) begin
      sum3 <= acc_sum;
    end
  end

  assign sum_valid = v3;
  assign sum_value = sum3;

endmodule

// ===== design/qdp_requant.sv =====
module qdp_requant #(
  parameter int ACC_WIDTH = qdp_pkg::ACC_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  qdp_pkg::qdp_cfg_t      cfg,
  input  logic                   sum_valid,
  output logic                   sum_ready,
  input  logic [ACC_WIDTH-1:0]   sum_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [15:0]     result_value,
  output logic                   saturated
);

  localparam int VW = (ACC_WIDTH > qdp_pkg::LSH_W) ? ACC_WIDTH : qdp_pkg::LSH_W;

  logic signed [31:0]          sum_n;
  logic signed [ACC_WIDTH-1:0] sum_w;
  logic signed [VW-1:0] v_ext;
  logic signed [VW-1:0] clamped;
  logic signed [VW-1:0] tmp;
  logic signed [VW-1:0] half;
  logic signed [VW-1:0] shifted;
  logic signed [VW-1:0] hi;
  logic signed [VW-1:0] lo;
  logic signed [VW-1:0] act;
  logic [4:0]           rsh_m1;
  logic [5:0]           lsh;
  logic signed [15:0]   res_next;
  logic                 sat_next;

  logic                 v4;
  logic signed [VW-1:0] val4;
  logic                 ready4, ready5;

  assign ready5    = !out_valid || out_ready;
  assign ready4    = !v4 || ready5;
  assign sum_ready = ready4;

  // read the sum at the width of the current mode
  assign sum_n = sum_value[31:0];
  assign sum_w = sum_value;
  assign v_ext = cfg.wide_mode ? (VW)'(sum_w) : (VW)'(sum_n);

  // requantization shift: round half up to the right, clamped shift to the left
  always_comb begin
    rsh_m1 = 5'(cfg.shift_amount[4:0] - 5'd1);
    lsh    = 6'(-cfg.shift_amount);
    tmp    = v_ext >>> rsh_m1;
    half   = '0;
    half[0] = tmp[0];
    clamped = v_ext;
    if (v_ext > (VW)'(qdp_pkg::LSH_LIMIT)) begin
      clamped = (VW)'(qdp_pkg::LSH_LIMIT);
    end else if (v_ext < (VW)'(-qdp_pkg::LSH_LIMIT)) begin
      clamped = (VW)'(-qdp_pkg::LSH_LIMIT);
    end
    if (cfg.shift_amount == 6'sd0) begin
      shifted = v_ext;
    end else if (cfg.shift_amount[5]) begin
      shifted = clamped <<< lsh;
    end else begin
      shifted = (tmp >>> 1) + half;
    end
  end

  // ReLU, then saturate to the mode's output range
  always_comb begin
    hi = cfg.wide_mode ? (VW)'(qdp_pkg::WIDE_MAX) : (VW)'(qdp_pkg::NARROW_MAX);
    lo = cfg.wide_mode ? (VW)'(qdp_pkg::WIDE_MIN) : (VW)'(qdp_pkg::NARROW_MIN);
    act = (cfg.relu_enable && val4[VW-1]) ? '0 : val4;
    sat_next = 1'b0;
    res_next = act[15:0];
    if (act > hi) begin
      res_next = hi[15:0];
      sat_next = 1'b1;
    end else if (act < lo) begin
      res_next = lo[15:0];
      sat_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ready4) begin
        v4 <= sum_valid;
      end
      if (ready5) begin
        out_valid <= v4;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready4) begin
      val4 <= shifted;
    end
    if (ready5) begin
      result_value <= res_next;
      saturated    <= sat_next;
    end
  end

endmodule

// ===== design/quantized_dot_product_requant.sv =====
// Stages: operand, product, sum, shift, output; the accumulator loop is one add.
// Throughput: one item per cycle unless out_ready stalls the output.
// Items without last_term give no result and only update the accumulator.
// Reset (rst, synchronous): clears the accumulator, all stage valids and the
// configuration (shift 0, ReLU off, int8 mode).
`include "quantized_dot_product_requant_defines.svh"

module quantized_dot_product_requant #(
  parameter int ACC_WIDTH = qdp_pkg::ACC_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [15:0]              a_value,
  input  logic signed [15:0]              b_value,
  input  logic                            last_term,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [15:0]              result_value,
  output logic                            saturated,
  input  logic                            cfg_write,
  input  logic [1:0]                      cfg_index,
  input  logic [qdp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  qdp_pkg::qdp_cfg_t    cfg;
  logic                 sum_valid;
  logic                 sum_ready;
  logic [ACC_WIDTH-1:0] sum_value;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        qdp_pkg::REG_SHIFT: cfg.shift_amount <= cfg_data;
        qdp_pkg::REG_RELU:  cfg.relu_enable  <= cfg_data[0];
        qdp_pkg::REG_WIDE:  cfg.wide_mode    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  qdp_mac #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .wide_mode (cfg.wide_mode),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .a_value   (a_value),
    .b_value   (b_value),
    .last_term (last_term),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum_value (sum_value)
  );

  qdp_requant #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_requant (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .sum_valid    (sum_valid),
    .sum_ready    (sum_ready),
    .sum_value    (sum_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_value (result_value),
    .saturated    (saturated)
  );

  // input stalls only when every stage is full behind a blocked output
  `QDP_ASSERT_IMPLY(a_stall_full, !in_ready, out_valid && !out_ready)
  `QDP_ASSERT_NEXT(a_stall_holds, !in_ready, out_valid)
  // ReLU never lets a negative value out
  `QDP_ASSERT_IMPLY(a_relu_nonneg, out_valid && cfg.relu_enable, !result_value[15])
  // int8 results stay in the byte range
  `QDP_ASSERT_IMPLY(a_narrow_range, out_valid && !cfg.wide_mode,
                    result_value[15:7] == 9'h000 || result_value[15:7] == 9'h1FF)

endmodule
